// ===== design/mcr_pkg.sv =====
package mcr_pkg;

    localparam int PIX_W     = 8;
    localparam int COORD_W   = 10;
    localparam int SUM_W     = 30;
    localparam int CNT_W     = 21;
    localparam int POS_W     = 11;
    localparam int SIZE_W    = 12;
    localparam int THR_W     = 8;
    localparam int HALF_W    = 9;
    localparam int DIM_W     = 11;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam logic [THR_W-1:0]  THR_RESET    = THR_W'(50);
    localparam logic [HALF_W-1:0] HALF_RESET   = HALF_W'(30);
    localparam logic [DIM_W-1:0]  WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0]  HEIGHT_RESET = DIM_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_HALF_SIZE = 2'd1,
        CFG_WIDTH     = 2'd2,
        CFG_HEIGHT    = 2'd3
    } cfg_idx_t;

endpackage

// ===== design/mcr_div.sv =====
module mcr_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [mcr_pkg::SUM_W-1:0]   dividend,
    input  logic [mcr_pkg::CNT_W-1:0]   divisor,
    output logic                        done,
    output logic [mcr_pkg::COORD_W-1:0] quotient
);
    import mcr_pkg::*;

    // quotient is known to fit in COORD_W bits, so only COORD_W restoring steps
    localparam int DEN_W  = CNT_W + COORD_W - 1;
    localparam int CMP_W  = (DEN_W > SUM_W) ? DEN_W : SUM_W;
    localparam int STEP_W = $clog2(COORD_W);

    logic [CMP_W-1:0]   rem_reg, rem_next;
    logic [CMP_W-1:0]   den_reg, den_next;
    logic [COORD_W-1:0] q_reg, q_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               fits;

    assign fits = (rem_reg >= den_reg);

    always_comb begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = CMP_W'(dividend);
            den_next  = CMP_W'({divisor, {(COORD_W-1){1'b0}}});
            step_next = STEP_W'(COORD_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = rem_reg - den_reg;
            end
            q_next   = {q_reg[COORD_W-2:0], fits};
            den_next = den_reg >> 1;
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        q_reg    <= q_next;
        step_reg <= step_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== design/motion_centroid_roi.sv =====
// Motion centroid with region of interest. One pixel word is taken per clock while
// the block is idle; moving pixels (|cur - prev| > threshold) add their column and row
// to saturating sums. The frame_end word closes the frame: s_ready then drops while
// one shared 10-step restoring divider forms the x and then the y centroid and two
// more steps clip the region; with no moving pixels the divider is skipped. The
// result waits in an output register, so pixels of the next frame are taken while
// it is unread; s_ready stays low longer only if a new result is ready before the
// previous one was taken.
module motion_centroid_roi #(
    parameter int MAX_WIDTH  = mcr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mcr_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mcr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mcr_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mcr_pkg::PIX_W-1:0]         s_cur_pixel,
    input  logic [mcr_pkg::PIX_W-1:0]         s_prev_pixel,
    input  logic [mcr_pkg::COORD_W-1:0]       s_col,
    input  logic [mcr_pkg::COORD_W-1:0]       s_row,
    input  logic                              s_frame_end,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [mcr_pkg::POS_W-1:0]  m_center_x,
    output logic signed [mcr_pkg::POS_W-1:0]  m_center_y,
    output logic [mcr_pkg::SUM_W-1:0]         m_total_x,
    output logic [mcr_pkg::SUM_W-1:0]         m_total_y,
    output logic [mcr_pkg::CNT_W-1:0]         m_moving_count,
    output logic signed [mcr_pkg::POS_W-1:0]  m_roi_left,
    output logic signed [mcr_pkg::POS_W-1:0]  m_roi_top,
    output logic signed [mcr_pkg::SIZE_W-1:0] m_roi_width,
    output logic signed [mcr_pkg::SIZE_W-1:0] m_roi_height
);
    import mcr_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LOADX  = 6'b000010,
        S_DIVX   = 6'b000100,
        S_DIVY   = 6'b001000,
        S_CORNER = 6'b010000,
        S_SIZE   = 6'b100000
    } state_t;

    localparam int EXT_W = DIM_W + 2;

    state_t state_reg, state_next;
    logic   send_reg, send_next;

    logic [THR_W-1:0]  thr_reg;
    logic [HALF_W-1:0] half_reg;
    logic [DIM_W-1:0]  fw_reg, fh_reg;

    logic [SUM_W-1:0] acc_x_reg, acc_x_next, acc_y_reg, acc_y_next;
    logic [CNT_W-1:0] acc_cnt_reg, acc_cnt_next;

    logic [SUM_W-1:0] sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic signed [POS_W-1:0]  cx_reg, cx_next, cy_reg, cy_next;
    logic signed [POS_W-1:0]  left_reg, left_next, top_reg, top_next;
    logic [DIM_W-1:0]         cols_reg, cols_next, rows_reg, rows_next;
    logic signed [SIZE_W-1:0] w_reg, w_next, h_reg, h_next;
    logic                     roi_ok_reg, roi_ok_next;

    logic                     m_valid_reg, m_valid_next;
    logic signed [POS_W-1:0]  m_cx_reg, m_cy_reg, m_left_reg, m_top_reg;
    logic signed [SIZE_W-1:0] m_w_reg, m_h_reg;
    logic [SUM_W-1:0]         m_tx_reg, m_ty_reg;
    logic [CNT_W-1:0]         m_cnt_reg;
    logic                     out_load;

    logic               pix_acc, moving;
    logic [PIX_W-1:0]   diff;
    logic [SUM_W:0]     x_sum, y_sum;
    logic [SUM_W-1:0]   x_sat, y_sat;
    logic [CNT_W-1:0]   cnt_sat;

    logic               div_start, div_done;
    logic [SUM_W-1:0]   div_dividend;
    logic [COORD_W-1:0] div_q;

    logic signed [POS_W:0] left_raw, top_raw;
    logic [HALF_W:0]       span;
    logic [EXT_W-1:0]      end_x, end_y, fit_w, fit_h;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE) && !send_reg;
    assign pix_acc   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= THR_RESET;
            half_reg <= HALF_RESET;
            fw_reg   <= WIDTH_RESET;
            fh_reg   <= HEIGHT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_THRESHOLD: thr_reg  <= cfg_data[THR_W-1:0];
                CFG_HALF_SIZE: half_reg <= cfg_data[HALF_W-1:0];
                CFG_WIDTH:     fw_reg   <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT:    fh_reg   <= cfg_data[DIM_W-1:0];
            endcase
        end
    end

    // pixel accumulation, saturating at all ones
    assign diff    = (s_cur_pixel >= s_prev_pixel) ? (s_cur_pixel - s_prev_pixel)
                                                   : (s_prev_pixel - s_cur_pixel);
    assign moving  = (diff > thr_reg);
    assign x_sum   = (SUM_W+1)'(acc_x_reg) + (SUM_W+1)'(s_col);
    assign y_sum   = (SUM_W+1)'(acc_y_reg) + (SUM_W+1)'(s_row);
    assign x_sat   = x_sum[SUM_W] ? {SUM_W{1'b1}} : x_sum[SUM_W-1:0];
    assign y_sat   = y_sum[SUM_W] ? {SUM_W{1'b1}} : y_sum[SUM_W-1:0];
    assign cnt_sat = (&acc_cnt_reg) ? acc_cnt_reg : acc_cnt_reg + CNT_W'(1);

    assign div_start    = ((state_reg == S_LOADX) && (cnt_reg != '0)) ||
                          ((state_reg == S_DIVX) && div_done);
    assign div_dividend = (state_reg == S_LOADX) ? sum_x_reg : sum_y_reg;

    mcr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign left_raw = $signed({cx_reg[POS_W-1], cx_reg}) - $signed({3'b000, half_reg});
    assign top_raw  = $signed({cy_reg[POS_W-1], cy_reg}) - $signed({3'b000, half_reg});
    assign span     = {half_reg, 1'b0};
    // corner is non-negative here, so plain unsigned math; wrap gives two's complement
    assign end_x    = EXT_W'(left_reg) + EXT_W'(span);
    assign end_y    = EXT_W'(top_reg) + EXT_W'(span);
    assign fit_w    = EXT_W'(cols_reg) - EXT_W'(left_reg);
    assign fit_h    = EXT_W'(rows_reg) - EXT_W'(top_reg);

    always_comb begin
        state_next   = state_reg;
        send_next    = send_reg;
        acc_x_next   = acc_x_reg;
        acc_y_next   = acc_y_reg;
        acc_cnt_next = acc_cnt_reg;
        sum_x_next   = sum_x_reg;
        sum_y_next   = sum_y_reg;
        cnt_next     = cnt_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        left_next    = left_reg;
        top_next     = top_reg;
        cols_next    = cols_reg;
        rows_next    = rows_reg;
        w_next       = w_reg;
        h_next       = h_reg;
        roi_ok_next  = roi_ok_reg;
        out_load     = 1'b0;

        if (pix_acc) begin
            if (moving) begin
                acc_x_next   = x_sat;
                acc_y_next   = y_sat;
                acc_cnt_next = cnt_sat;
            end
            if (s_frame_end) begin
                sum_x_next   = acc_x_next;
                sum_y_next   = acc_y_next;
                cnt_next     = acc_cnt_next;
                acc_x_next   = '0;
                acc_y_next   = '0;
                acc_cnt_next = '0;
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (pix_acc && s_frame_end) begin
                    state_next = S_LOADX;
                end
            end
            S_LOADX: begin
                if (cnt_reg == '0) begin
                    cx_next    = '1;
                    cy_next    = '1;
                    state_next = S_CORNER;
                end else begin
                    state_next = S_DIVX;
                end
            end
            S_DIVX: begin
                if (div_done) begin
                    cx_next    = POS_W'(div_q);
                    state_next = S_DIVY;
                end
            end
            S_DIVY: begin
                if (div_done) begin
                    cy_next    = POS_W'(div_q);
                    state_next = S_CORNER;
                end
            end
            S_CORNER: begin
                roi_ok_next = !cx_reg[POS_W-1] && (cx_reg != '0);
                left_next   = left_raw[POS_W] ? '0 : left_raw[POS_W-1:0];
                top_next    = top_raw[POS_W]  ? '0 : top_raw[POS_W-1:0];
                cols_next   = (int'(fw_reg) > MAX_WIDTH)  ? DIM_W'(MAX_WIDTH)  : fw_reg;
                rows_next   = (int'(fh_reg) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : fh_reg;
                state_next  = S_SIZE;
            end
            S_SIZE: begin
                if (roi_ok_reg) begin
                    w_next = (end_x > EXT_W'(cols_reg)) ? fit_w[SIZE_W-1:0] : SIZE_W'(span);
                    h_next = (end_y > EXT_W'(rows_reg)) ? fit_h[SIZE_W-1:0] : SIZE_W'(span);
                end else begin
                    left_next = '1;
                    top_next  = '1;
                    w_next    = '1;
                    h_next    = '1;
                end
                send_next  = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // pending result word waits for the output register
        if (send_reg) begin
            if (!m_valid_reg || m_ready) begin
                out_load  = 1'b1;
                send_next = 1'b0;
            end else begin
                state_next = state_reg;
            end
        end
    end

    // s_ready is held low in S_IDLE while a result word waits: a waiting word blocks
    // only while state is IDLE, so the ready side is gated by send_reg too
    assign m_valid_next = out_load || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            send_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            acc_x_reg   <= '0;
            acc_y_reg   <= '0;
            acc_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            send_reg    <= send_next;
            m_valid_reg <= m_valid_next;
            acc_x_reg   <= acc_x_next;
            acc_y_reg   <= acc_y_next;
            acc_cnt_reg <= acc_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_x_reg  <= sum_x_next;
        sum_y_reg  <= sum_y_next;
        cnt_reg    <= cnt_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        left_reg   <= left_next;
        top_reg    <= top_next;
        cols_reg   <= cols_next;
        rows_reg   <= rows_next;
        w_reg      <= w_next;
        h_reg      <= h_next;
        roi_ok_reg <= roi_ok_next;
        if (out_load) begin
            m_cx_reg   <= cx_reg;
            m_cy_reg   <= cy_reg;
            m_tx_reg   <= sum_x_reg;
            m_ty_reg   <= sum_y_reg;
            m_cnt_reg  <= cnt_reg;
            m_left_reg <= left_next;
            m_top_reg  <= top_next;
            m_w_reg    <= w_next;
            m_h_reg    <= h_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_center_x     = m_cx_reg;
    assign m_center_y     = m_cy_reg;
    assign m_total_x      = m_tx_reg;
    assign m_total_y      = m_ty_reg;
    assign m_moving_count = m_cnt_reg;
    assign m_roi_left     = m_left_reg;
    assign m_roi_top      = m_top_reg;
    assign m_roi_width    = m_w_reg;
    assign m_roi_height   = m_h_reg;

endmodule

// ===== design/mcr_checker.sv =====
module mcr_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              s_frame_end,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [mcr_pkg::POS_W-1:0]  m_center_x,
    input logic [mcr_pkg::CNT_W-1:0]         m_moving_count,
    input logic signed [mcr_pkg::POS_W-1:0]  m_roi_left,
    input logic signed [mcr_pkg::SIZE_W-1:0] m_roi_width,
    input logic signed [mcr_pkg::SIZE_W-1:0] m_roi_height
);
    import mcr_pkg::*;

    // frame end starts the centroid sequence
    a_busy_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_frame_end) |=> !s_ready)
        else $error("s_ready high right after frame end word");

    // ordinary pixels are absorbed without a stall
    a_pixel_stream: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_frame_end) |=> s_ready)
        else $error("s_ready dropped after ordinary pixel");

    a_no_motion: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_moving_count == '0) == (m_center_x == -11'sd1)))
        else $error("centroid marker disagrees with moving count");

    a_roi_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_center_x < 11'sd1)) |->
        ((m_roi_left == -11'sd1) && (m_roi_width == -12'sd1) &&
         (m_roi_height == -12'sd1)))
        else $error("region not cleared for non-positive centroid");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_center_x)))
        else $error("result word changed while stalled");

endmodule

bind motion_centroid_roi mcr_checker u_mcr_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_frame_end    (s_frame_end),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_center_x     (m_center_x),
    .m_moving_count (m_moving_count),
    .m_roi_left     (m_roi_left),
    .m_roi_width    (m_roi_width),
    .m_roi_height   (m_roi_height)
);
